@@ rtl/ckcb_pkg.sv @@
`default_nettype none

package ckcb_pkg;

    // Framebuffer line pitch in bytes.
    localparam int LINE_PITCH = 1024;

    // Field widths.
    localparam int PIXEL_W = 8;
    localparam int GEOM_W  = 13;
    localparam int COUNT_W = 12;
    localparam int POS_W   = GEOM_W + 1;
    localparam int ADDR_W  = 25;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 13;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BLIT_WIDTH    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BLIT_HEIGHT   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_KEY     = 3'd7;

    // Reset values of the registers.
    localparam logic [GEOM_W-1:0] RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [GEOM_W-1:0] RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [GEOM_W-1:0] RST_BLIT_WIDTH    = 13'd1;
    localparam logic [GEOM_W-1:0] RST_BLIT_HEIGHT   = 13'd1;

    // Register file contents as seen by the datapath.
    typedef struct packed {
        logic                      output_enable;
        logic [GEOM_W-1:0]         screen_width;
        logic [GEOM_W-1:0]         screen_height;
        logic signed [GEOM_W-1:0]  dest_x;
        logic signed [GEOM_W-1:0]  dest_y;
        logic [GEOM_W-1:0]         blit_width;
        logic [GEOM_W-1:0]         blit_height;
        logic [PIXEL_W-1:0]        color_key;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/ckcb_config.sv @@
`default_nettype none

module ckcb_config (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_en,
    input  wire logic [ckcb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ckcb_pkg::CFG_DATA_W-1:0]   cfg_data,
    output ckcb_pkg::cfg_t                         cfg,
    output logic                                   geom_clear
);

    ckcb_pkg::cfg_t cfg_reg;
    ckcb_pkg::cfg_t cfg_next;

    // Decode a register write.
    always_comb
    begin
        cfg_next   = cfg_reg;
        geom_clear = 1'b0;
        if (cfg_en)
        begin
            unique case (cfg_index)
                ckcb_pkg::REG_OUTPUT_ENABLE: cfg_next.output_enable = cfg_data[0];
                ckcb_pkg::REG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data;
                ckcb_pkg::REG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data;
                ckcb_pkg::REG_DEST_X:
                begin
                    cfg_next.dest_x = cfg_data;
                    geom_clear      = 1'b1;
                end
                ckcb_pkg::REG_DEST_Y:
                begin
                    cfg_next.dest_y = cfg_data;
                    geom_clear      = 1'b1;
                end
                ckcb_pkg::REG_BLIT_WIDTH:
                begin
                    cfg_next.blit_width = cfg_data;
                    geom_clear          = 1'b1;
                end
                ckcb_pkg::REG_BLIT_HEIGHT:
                begin
                    cfg_next.blit_height = cfg_data;
                    geom_clear           = 1'b1;
                end
                ckcb_pkg::REG_COLOR_KEY: cfg_next.color_key = cfg_data[ckcb_pkg::PIXEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Register storage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.output_enable <= 1'b0;
            cfg_reg.screen_width  <= ckcb_pkg::RST_SCREEN_WIDTH;
            cfg_reg.screen_height <= ckcb_pkg::RST_SCREEN_HEIGHT;
            cfg_reg.dest_x        <= '0;
            cfg_reg.dest_y        <= '0;
            cfg_reg.blit_width    <= ckcb_pkg::RST_BLIT_WIDTH;
            cfg_reg.blit_height   <= ckcb_pkg::RST_BLIT_HEIGHT;
            cfg_reg.color_key     <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/ckcb_raster.sv @@
`default_nettype none

module ckcb_raster (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire ckcb_pkg::cfg_t                      cfg,
    input  wire logic                                geom_clear,
    input  wire logic                                advance,
    output logic signed [ckcb_pkg::POS_W-1:0]        screen_x,
    output logic signed [ckcb_pkg::POS_W-1:0]        screen_y
);

    logic [ckcb_pkg::COUNT_W-1:0] column_reg;
    logic [ckcb_pkg::COUNT_W-1:0] column_next;
    logic [ckcb_pkg::COUNT_W-1:0] row_reg;
    logic [ckcb_pkg::COUNT_W-1:0] row_next;
    logic [ckcb_pkg::COUNT_W:0]   column_inc;
    logic [ckcb_pkg::COUNT_W:0]   row_inc;
    logic                         column_wrap;
    logic                         row_wrap;

    // Step the counters: wrap at the sprite size or at 12-bit roll-over.
    always_comb
    begin
        column_inc  = {1'b0, column_reg} + 1'b1;
        row_inc     = {1'b0, row_reg} + 1'b1;
        column_wrap = (column_inc >= cfg.blit_width) || column_inc[ckcb_pkg::COUNT_W];
        row_wrap    = (row_inc >= cfg.blit_height) || row_inc[ckcb_pkg::COUNT_W];
        column_next = column_reg;
        row_next    = row_reg;
        if (geom_clear)
        begin
            column_next = '0;
            row_next    = '0;
        end
        else if (advance)
        begin
            column_next = column_wrap ? '0 : column_inc[ckcb_pkg::COUNT_W-1:0];
            if (column_wrap)
            begin
                row_next = row_wrap ? '0 : row_inc[ckcb_pkg::COUNT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    // Screen position of the current pixel.
    assign screen_x = {cfg.dest_x[ckcb_pkg::GEOM_W-1], cfg.dest_x}
                    + $signed({2'b00, column_reg});
    assign screen_y = {cfg.dest_y[ckcb_pkg::GEOM_W-1], cfg.dest_y}
                    + $signed({2'b00, row_reg});

endmodule

`default_nettype wire

@@ rtl/ckcb_clip.sv @@
`default_nettype none

module ckcb_clip (
    input  wire ckcb_pkg::cfg_t                       cfg,
    input  wire logic [ckcb_pkg::PIXEL_W-1:0]         pixel,
    input  wire logic signed [ckcb_pkg::POS_W-1:0]    screen_x,
    input  wire logic signed [ckcb_pkg::POS_W-1:0]    screen_y,
    output logic                                      keep,
    output logic [ckcb_pkg::ADDR_W-1:0]               address
);

    logic        visible;
    logic [27:0] address_full;

    // Clip against the screen, drop the transparent colour and honour the output enable.
    always_comb
    begin
        visible = !screen_x[ckcb_pkg::POS_W-1] && !screen_y[ckcb_pkg::POS_W-1]
               && (screen_x[ckcb_pkg::GEOM_W-1:0] < cfg.screen_width)
               && (screen_y[ckcb_pkg::GEOM_W-1:0] < cfg.screen_height);
        keep    = cfg.output_enable && visible && (pixel != cfg.color_key);
    end

    // Linear framebuffer offset, taken modulo the address width.
    assign address_full = 28'(screen_y[ckcb_pkg::GEOM_W-1:0]) * 28'(ckcb_pkg::LINE_PITCH)
                        + 28'(screen_x[ckcb_pkg::GEOM_W-1:0]);
    assign address = address_full[ckcb_pkg::ADDR_W-1:0];

endmodule

`default_nettype wire

@@ rtl/color_keyed_clipped_blit.sv @@
// Channel   Direction  Handshake             Payload
// in        sink       in_valid / in_stall   pixel
// out       source     out_valid / out_stall write_address, write_data
// cfg       sink       cfg_en                cfg_index, cfg_data
//
// One pixel is taken per clock while in_stall is low; its request is registered in both stages.
// The pipe has two stages: input register, then result register.
// Clipped or keyed-out pixels leave no request but still step the raster counters.
// An asynchronous reset sets the config registers and clears the counters and both valid flags.
// A stall at the output fills the result register, then the input register,
// and only then raises in_stall.
`default_nettype none

module color_keyed_clipped_blit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [ckcb_pkg::PIXEL_W-1:0]      pixel,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [ckcb_pkg::ADDR_W-1:0]            write_address,
    output logic [ckcb_pkg::PIXEL_W-1:0]           write_data,
    input  wire logic                              cfg_en,
    input  wire logic [ckcb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ckcb_pkg::CFG_DATA_W-1:0]   cfg_data
);

    ckcb_pkg::cfg_t                      cfg;
    logic                                geom_clear;
    logic                                accept;
    logic                                out_free;
    logic signed [ckcb_pkg::POS_W-1:0]   screen_x;
    logic signed [ckcb_pkg::POS_W-1:0]   screen_y;
    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    logic [ckcb_pkg::PIXEL_W-1:0]        s1_pixel_reg;
    logic signed [ckcb_pkg::POS_W-1:0]   s1_x_reg;
    logic signed [ckcb_pkg::POS_W-1:0]   s1_y_reg;
    logic                                keep;
    logic [ckcb_pkg::ADDR_W-1:0]         address;
    logic                                out_valid_reg;
    logic [ckcb_pkg::ADDR_W-1:0]         out_address_reg;
    logic [ckcb_pkg::PIXEL_W-1:0]        out_data_reg;

    ckcb_config u_config (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_en     (cfg_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cfg        (cfg),
        .geom_clear (geom_clear)
    );

    ckcb_raster u_raster (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .geom_clear (geom_clear),
        .advance    (accept),
        .screen_x   (screen_x),
        .screen_y   (screen_y)
    );

    ckcb_clip u_clip (
        .cfg      (cfg),
        .pixel    (s1_pixel_reg),
        .screen_x (s1_x_reg),
        .screen_y (s1_y_reg),
        .keep     (keep),
        .address  (address)
    );

    // Flow control: the result register frees when empty or taken.
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            s1_valid_next = 1'b0;
        end
    end

    // Input stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Input stage payload: pixel and its screen position.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg <= pixel;
            s1_x_reg     <= screen_x;
            s1_y_reg     <= screen_y;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg && keep;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_address_reg <= address;
            out_data_reg    <= s1_pixel_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign write_address = out_address_reg;
    assign write_data    = out_data_reg;

    // The input stage only stalls while it holds a pixel.
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input stage");

    // A kept pixel that moves on always becomes a request.
    a_keep_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_free && keep |=> out_valid_reg)
        else $error("kept pixel lost between stages");

    // A pixel held back by a stall stays in the input stage.
    a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_pixel_reg))
        else $error("input stage dropped a stalled pixel");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
module tb_top;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int PIPE_SETTLE = 6;
    localparam int PHASE_PIXELS = 95;

    typedef struct packed {
        logic [ckcb_pkg::ADDR_W-1:0]  addr;
        logic [ckcb_pkg::PIXEL_W-1:0] data;
    } fb_write_t;

    // Clock, reset and the block's inputs, all known from time zero.
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic [ckcb_pkg::PIXEL_W-1:0]    pixel = '0;
    logic                            out_stall = 1'b0;
    logic                            cfg_en = 1'b0;
    logic [ckcb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ckcb_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                            in_stall;
    logic                            out_valid;
    logic [ckcb_pkg::ADDR_W-1:0]     write_address;
    logic [ckcb_pkg::PIXEL_W-1:0]    write_data;

    // Pixels waiting to be sent and framebuffer writes still to arrive.
    logic [ckcb_pkg::PIXEL_W-1:0]    pixel_backlog[$];
    fb_write_t                       pending_writes[$];
    logic                            pix_taken = 1'b0;
    int                              send_idle_pct = 0;
    int                              recv_stall_pct = 0;
    int                              mismatches = 0;
    int                              writes_seen = 0;
    int                              cycle_count = 0;

    // Shadow of the register file and the raster counters.
    logic                               fb_enable = 1'b0;
    logic [ckcb_pkg::GEOM_W-1:0]        scr_w = ckcb_pkg::RST_SCREEN_WIDTH;
    logic [ckcb_pkg::GEOM_W-1:0]        scr_h = ckcb_pkg::RST_SCREEN_HEIGHT;
    logic signed [ckcb_pkg::GEOM_W-1:0] org_x = '0;
    logic signed [ckcb_pkg::GEOM_W-1:0] org_y = '0;
    logic [ckcb_pkg::GEOM_W-1:0]        sprite_w = ckcb_pkg::RST_BLIT_WIDTH;
    logic [ckcb_pkg::GEOM_W-1:0]        sprite_h = ckcb_pkg::RST_BLIT_HEIGHT;
    logic [ckcb_pkg::PIXEL_W-1:0]       fb_key = '0;
    logic [ckcb_pkg::COUNT_W-1:0]       raster_col = '0;
    logic [ckcb_pkg::COUNT_W-1:0]       raster_row = '0;

    color_keyed_clipped_blit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .pixel         (pixel),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_address (write_address),
        .write_data    (write_data),
        .cfg_en        (cfg_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Mirror a register write; any change of position or sprite size restarts the sprite.
    task automatic apply_register(input logic [ckcb_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [ckcb_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            ckcb_pkg::REG_OUTPUT_ENABLE: fb_enable = val[0];
            ckcb_pkg::REG_SCREEN_WIDTH:  scr_w = val;
            ckcb_pkg::REG_SCREEN_HEIGHT: scr_h = val;
            ckcb_pkg::REG_DEST_X:        org_x = val;
            ckcb_pkg::REG_DEST_Y:        org_y = val;
            ckcb_pkg::REG_BLIT_WIDTH:    sprite_w = val;
            ckcb_pkg::REG_BLIT_HEIGHT:   sprite_h = val;
            ckcb_pkg::REG_COLOR_KEY:     fb_key = val[ckcb_pkg::PIXEL_W-1:0];
            default:                     ;
        endcase
        if (idx == ckcb_pkg::REG_DEST_X || idx == ckcb_pkg::REG_DEST_Y ||
            idx == ckcb_pkg::REG_BLIT_WIDTH || idx == ckcb_pkg::REG_BLIT_HEIGHT)
        begin
            raster_col = '0;
            raster_row = '0;
        end
    endtask

    // Clip and key one source pixel, then step the raster counters.
    task automatic blit_pixel(input logic [ckcb_pkg::PIXEL_W-1:0] pix);
        int        sx;
        int        sy;
        int        step;
        fb_write_t wr;
        sx = org_x;
        sy = org_y;
        sx = sx + int'(raster_col);
        sy = sy + int'(raster_row);
        if (fb_enable && pix != fb_key && sx >= 0 && sy >= 0 &&
            sx < int'(scr_w) && sy < int'(scr_h))
        begin
            wr.addr = ckcb_pkg::ADDR_W'(sy * ckcb_pkg::LINE_PITCH + sx);
            wr.data = pix;
            pending_writes.push_back(wr);
        end
        step = int'(raster_col) + 1;
        if (step >= int'(sprite_w) || step >= (1 << ckcb_pkg::COUNT_W))
        begin
            raster_col = '0;
            step = int'(raster_row) + 1;
            if (step >= int'(sprite_h) || step >= (1 << ckcb_pkg::COUNT_W))
                raster_row = '0;
            else
                raster_row = ckcb_pkg::COUNT_W'(step);
        end
        else
        begin
            raster_col = ckcb_pkg::COUNT_W'(step);
        end
    endtask

    // Compare one framebuffer write with the oldest one predicted.
    task automatic check_write();
        fb_write_t want;
        if (pending_writes.size() == 0)
        begin
            if (mismatches < 10)
                $display("write %0d: none predicted, got addr %h data %h",
                         writes_seen, write_address, write_data);
            mismatches++;
        end
        else
        begin
            want = pending_writes.pop_front();
            if (want.addr !== write_address || want.data !== write_data)
            begin
                if (mismatches < 10)
                    $display("write %0d: expected addr %h data %h, got addr %h data %h",
                             writes_seen, want.addr, want.data, write_address,
                             write_data);
                mismatches++;
            end
        end
        writes_seen++;
    endtask

    // Sample both handshakes and the configuration port at the rising edge.
    always @(posedge clk)
    begin
        pix_taken <= rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (cfg_en)
                apply_register(cfg_index, cfg_data);
            if (in_valid && !in_stall)
                blit_pixel(pixel);
            if (out_valid && !out_stall)
                check_write();
        end
    end

    // Pixel driver: a request is held until taken, then the next one may follow.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || pix_taken)
        begin
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                pixel <= pixel_backlog.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Framebuffer side back-pressure.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [ckcb_pkg::CFG_IDX_W-1:0] idx, input int val);
        cfg_index <= idx;
        cfg_data <= ckcb_pkg::CFG_DATA_W'(val);
        cfg_en <= 1'b1;
        @(negedge clk);
        cfg_en <= 1'b0;
    endtask

    task automatic program_blit(input int oe, input int sw, input int sh,
                                input int dx, input int dy, input int bw,
                                input int bh, input int key);
        write_reg(ckcb_pkg::REG_OUTPUT_ENABLE, oe);
        write_reg(ckcb_pkg::REG_SCREEN_WIDTH, sw);
        write_reg(ckcb_pkg::REG_SCREEN_HEIGHT, sh);
        write_reg(ckcb_pkg::REG_DEST_X, dx);
        write_reg(ckcb_pkg::REG_DEST_Y, dy);
        write_reg(ckcb_pkg::REG_BLIT_WIDTH, bw);
        write_reg(ckcb_pkg::REG_BLIT_HEIGHT, bh);
        write_reg(ckcb_pkg::REG_COLOR_KEY, key);
    endtask

    // Wait until every pixel is sent and every write is in, then let the pipe empty.
    task automatic settle();
        int waited;
        waited = 0;
        @(posedge clk);
        while (pixel_backlog.size() != 0 || in_valid)
            @(posedge clk);
        @(negedge clk);
        while (pending_writes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (PIPE_SETTLE) @(negedge clk);
        if (pending_writes.size() != 0)
        begin
            if (mismatches < 10)
                $display("%0d predicted write(s) never arrived", pending_writes.size());
            mismatches += pending_writes.size();
            pending_writes.delete();
        end
    endtask

    initial
    begin
        int k;
        int i;
        int oe;
        int sw;
        int sh;
        int dx;
        int dy;
        int bw;
        int bh;
        int key;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: pixel extremes and a keyed pixel on an open screen.
        send_idle_pct = 12;
        recv_stall_pct = 80;
        program_blit(1, 640, 480, 0, 0, 4, 2, 0);
        pixel_backlog = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE};
        settle();

        // Directed: a sprite overhanging every side of a tiny screen.
        program_blit(1, 2, 2, -1, -1, 4, 4, 8'h33);
        for (i = 0; i < 16; i++)
            pixel_backlog.push_back((i % 5 == 2) ? 8'h33 : 8'($urandom_range(255)));
        settle();

        // Random sprites, with a special geometry in some of the phases.
        for (k = 0; k < 12; k++)
        begin
            if (k == 4)
            begin
                send_idle_pct = 80;
                recv_stall_pct = 12;
            end
            else if (k == 8)
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            oe = ($urandom_range(9) != 0);
            sw = $urandom_range(1, 48);
            sh = $urandom_range(1, 48);
            dx = int'($urandom_range(56)) - 8;
            dy = int'($urandom_range(56)) - 8;
            bw = $urandom_range(1, 16);
            bh = $urandom_range(1, 12);
            key = $urandom_range(255);
            case (k)
                0: oe = 0;
                1: sw = 0;
                2: sh = 0;
                3:
                begin
                    bw = 0;
                    bh = 0;
                    oe = 1;
                end
                5:
                begin
                    dx = 4095;
                    dy = 4095;
                    sw = 8191;
                    sh = 8191;
                    oe = 1;
                end
                6:
                begin
                    dx = -4096;
                    dy = -4096;
                    oe = 1;
                end
                7:
                begin
                    dx = 1020;
                    sw = 8191;
                    sh = 8191;
                    key = 255;
                    oe = 1;
                end
                9:
                begin
                    bw = 8191;
                    bh = 8191;
                end
                default: ;
            endcase
            // Some phases leave the geometry alone so the sprite carries on.
            if (k == 4 || k == 10)
            begin
                write_reg(ckcb_pkg::REG_OUTPUT_ENABLE, oe);
                write_reg(ckcb_pkg::REG_SCREEN_WIDTH, sw);
                write_reg(ckcb_pkg::REG_SCREEN_HEIGHT, sh);
                write_reg(ckcb_pkg::REG_COLOR_KEY, key);
            end
            else
            begin
                program_blit(oe, sw, sh, dx, dy, bw, bh, key);
            end
            for (i = 0; i < PHASE_PIXELS; i++)
                pixel_backlog.push_back(($urandom_range(99) < 15) ? 8'(key)
                                        : 8'($urandom_range(255)));
            settle();
        end

        if (mismatches == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule
